/* rtl/core/mips_alu_with_hi_lo_unit_macros.svh */
// Assertion macros shared by the ALU top level.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIPS_ALU_WITH_HI_LO_UNIT_MACROS_SVH
`define MIPS_ALU_WITH_HI_LO_UNIT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define MALU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define MALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/malu_pkg.sv */
// Shared types and codes for the MIPS ALU with HI/LO unit.
// No dependencies.
package malu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_ADDIU = 5'd0,
    OP_ADDU  = 5'd1,
    OP_SUBU  = 5'd2,
    OP_AND   = 5'd3,
    OP_ANDI  = 5'd4,
    OP_OR    = 5'd5,
    OP_ORI   = 5'd6,
    OP_XOR   = 5'd7,
    OP_XORI  = 5'd8,
    OP_SLL   = 5'd9,
    OP_SRA   = 5'd10,
    OP_SRL   = 5'd11,
    OP_SLLV  = 5'd12,
    OP_SRAV  = 5'd13,
    OP_SRLV  = 5'd14,
    OP_MULT  = 5'd15,
    OP_MULTU = 5'd16,
    OP_DIV   = 5'd17,
    OP_DIVU  = 5'd18,
    OP_MTHI  = 5'd19,
    OP_MTLO  = 5'd20,
    OP_MFHI  = 5'd21,
    OP_MFLO  = 5'd22
  } op_t;

  // Command to the iterative multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_mul;
    logic is_signed;
  } md_cmd_t;

endpackage

/* rtl/core/malu_req_if.sv */
// Request channel: operation code and two operands, valid/ready handshake.
// No dependencies.
interface malu_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

/* rtl/core/malu_rsp_if.sv */
// Response channel: 32-bit result and divide-by-zero flag, valid/ready handshake.
// No dependencies.
interface malu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

/* rtl/core/malu_alu.sv */
// Combinational datapath: add/sub, logic ops, shifts, moves from HI/LO.
// Depends on malu_pkg.
module malu_alu (
  input  logic [4:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] hi,
  input  logic [31:0] lo,
  output logic [31:0] result
);

  logic [4:0]  sh;
  logic [31:0] imm_z;
  logic [31:0] imm_s;

  assign sh    = b[4:0];
  assign imm_z = {16'h0000, b[15:0]};
  assign imm_s = {{16{b[15]}}, b[15:0]};

  always_comb begin
    unique case (malu_pkg::op_t'(op))
      malu_pkg::OP_ADDIU: result = a + imm_s;
      malu_pkg::OP_ADDU:  result = a + b;
      malu_pkg::OP_SUBU:  result = a - b;
      malu_pkg::OP_AND:   result = a & b;
      malu_pkg::OP_ANDI:  result = a & imm_z;
      malu_pkg::OP_OR:    result = a | b;
      malu_pkg::OP_ORI:   result = a | imm_z;
      malu_pkg::OP_XOR:   result = a ^ b;
      malu_pkg::OP_XORI:  result = a ^ imm_z;
      malu_pkg::OP_SLL,
      malu_pkg::OP_SLLV:  result = a << sh;
      malu_pkg::OP_SRA,
      malu_pkg::OP_SRAV:  result = $unsigned($signed(a) >>> sh);
      malu_pkg::OP_SRL,
      malu_pkg::OP_SRLV:  result = a >> sh;
      malu_pkg::OP_MFHI:  result = hi;
      malu_pkg::OP_MFLO:  result = lo;
      default:            result = '0;
    endcase
  end

endmodule

/* rtl/core/malu_muldiv.sv */
// Iterative multiply/divide: one shared 34-bit adder, one bit per cycle.
// Depends on malu_pkg for the command struct.
module malu_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  malu_pkg::md_cmd_t cmd,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       hi_res,
  output logic [31:0]       lo_res
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_FIX  = 3'b100
  } md_state_t;

  md_state_t   state;
  md_state_t   state_next;
  logic [31:0] acc;     // product high half / partial remainder
  logic [31:0] q;       // multiplier -> product low half / dividend -> quotient
  logic [31:0] m;       // multiplicand / divisor
  logic [4:0]  cnt;
  logic        is_mul;
  logic        neg_q;   // negate product (mul) or quotient (div)
  logic        neg_r;   // negate remainder

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] shifted;
  logic [33:0] add_x;
  logic [33:0] add_y;
  logic [33:0] sum;
  logic [63:0] prod;
  logic [63:0] prod_fix;

  assign mag_a = (cmd.is_signed && a[31]) ? (32'd0 - a) : a;
  assign mag_b = (cmd.is_signed && b[31]) ? (32'd0 - b) : b;

  // Shared adder: shift-add for multiply, trial subtract for divide.
  assign shifted = {acc, q[31]};
  assign add_x   = is_mul ? {2'b00, acc} : {1'b0, shifted};
  assign add_y   = is_mul ? (q[0] ? {2'b00, m} : 34'd0) : ~{2'b00, m};
  assign sum     = add_x + add_y + {33'd0, ~is_mul};

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (cmd.start) state_next = MD_RUN;
      MD_RUN:  if (cnt == 5'd31) state_next = MD_FIX;
      MD_FIX:  state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == MD_RUN) cnt <= cnt + 5'd1;
      else cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == MD_IDLE && cmd.start) begin
      acc    <= '0;
      q      <= mag_a;
      m      <= mag_b;
      is_mul <= cmd.is_mul;
      neg_q  <= cmd.is_signed && (a[31] ^ b[31]);
      neg_r  <= cmd.is_signed && a[31];
    end else if (state == MD_RUN) begin
      if (is_mul) begin
        acc <= sum[32:1];
        q   <= {sum[0], q[31:1]};
      end else if (!sum[33]) begin
        acc <= sum[31:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        acc <= shifted[31:0];
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  // Sign fix-up in the last cycle.
  assign prod     = {acc, q};
  assign prod_fix = neg_q ? (64'd0 - prod) : prod;

  always_comb begin
    if (is_mul) begin
      hi_res = prod_fix[63:32];
      lo_res = prod_fix[31:0];
    end else begin
      hi_res = neg_r ? (32'd0 - acc) : acc;
      lo_res = neg_q ? (32'd0 - q) : q;
    end
  end

  assign done = (state == MD_FIX);

endmodule

/* rtl/core/mips_alu_with_hi_lo_unit.sv */
// MIPS32 integer ALU with HI/LO registers. Add/sub, logic, immediate and
// shift ops are combinational: the result lands in the output register
// at the edge of the request beat, so the response beat can follow in
// the next cycle. mult, multu, div and divu run on a shared iterative unit,
// one bit per cycle through a single 34-bit adder: the iteration state
// MD_RUN, then the sign fix-up state MD_FIX, after which the output
// register loads. req.ready stays low until then, so no new request is
// taken while a mul/div runs. mult, multu, div, divu, mthi and mtlo give
// result 0. A zero divisor is handled like an ALU op, with divide_by_zero
// set, result 0, and HI/LO untouched; signed overflow wraps.
// A new request is taken only when the output register is empty or its
// beat is being taken in the same cycle. HI and LO reset to zero.
// Depends on malu_pkg, malu_req_if, malu_rsp_if, malu_alu, malu_muldiv.
`include "mips_alu_with_hi_lo_unit_macros.svh"

module mips_alu_with_hi_lo_unit (
  input logic        clk,
  input logic        rst,
  malu_req_if.sink   req,
  malu_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_MULDIV = 2'b10
  } state_t;

  state_t            state;
  logic [31:0]       hi;
  logic [31:0]       lo;
  logic              out_valid;
  logic [31:0]       out_result;
  logic              out_dz;

  logic              accept;
  logic              b_zero;
  logic              is_md;      // op goes to the iterative unit
  logic              is_divz;    // div/divu with zero divisor
  logic [31:0]       alu_result;
  malu_pkg::md_cmd_t md_cmd;
  logic              md_done;
  logic [31:0]       md_hi;
  logic [31:0]       md_lo;
  malu_pkg::op_t     op_dec;

  assign op_dec  = malu_pkg::op_t'(req.op);
  assign b_zero  = (req.operand_b == 32'd0);

  always_comb begin
    is_md   = 1'b0;
    is_divz = 1'b0;
    md_cmd  = '0;
    unique case (op_dec)
      malu_pkg::OP_MULT: begin
        is_md            = 1'b1;
        md_cmd.is_mul    = 1'b1;
        md_cmd.is_signed = 1'b1;
      end
      malu_pkg::OP_MULTU: begin
        is_md         = 1'b1;
        md_cmd.is_mul = 1'b1;
      end
      malu_pkg::OP_DIV: begin
        is_md            = !b_zero;
        is_divz          = b_zero;
        md_cmd.is_signed = 1'b1;
      end
      malu_pkg::OP_DIVU: begin
        is_md   = !b_zero;
        is_divz = b_zero;
      end
      default: begin
      end
    endcase
    md_cmd.start = accept && is_md;
  end

  // Output slot must be free (or draining) before a new request is taken.
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  malu_alu u_alu (
    .op     (req.op),
    .a      (req.operand_a),
    .b      (req.operand_b),
    .hi     (hi),
    .lo     (lo),
    .result (alu_result)
  );

  malu_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .cmd    (md_cmd),
    .a      (req.operand_a),
    .b      (req.operand_b),
    .done   (md_done),
    .hi_res (md_hi),
    .lo_res (md_lo)
  );

  // Control: sequencer state and output valid.
  // A new beat loading the slot wins over the drain of the old one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && is_md) begin
            state     <= ST_MULDIV;
            out_valid <= 1'b0;
          end else if (accept) begin
            out_valid <= 1'b1;
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_MULDIV: begin
          if (md_done) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Architectural HI/LO.
  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= '0;
      lo <= '0;
    end else if (state == ST_MULDIV && md_done) begin
      hi <= md_hi;
      lo <= md_lo;
    end else if (accept && op_dec == malu_pkg::OP_MTHI) begin
      hi <= req.operand_a;
    end else if (accept && op_dec == malu_pkg::OP_MTLO) begin
      lo <= req.operand_a;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept && !is_md) begin
      out_result <= alu_result;
      out_dz     <= is_divz;
    end else if (state == ST_MULDIV && md_done) begin
      out_result <= '0;
      out_dz     <= 1'b0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result         = out_result;
  assign rsp.divide_by_zero = out_dz;

  `MALU_ASSERT_SAME(a_accept_slot_free, clk, rst, req.valid && req.ready, !rsp.valid || rsp.ready, "request taken while output slot full")
  `MALU_ASSERT_SAME(a_busy_not_ready, clk, rst, state == ST_MULDIV, !req.ready, "ready raised during multiply/divide")
  `MALU_ASSERT_SAME(a_dz_result_zero, clk, rst, rsp.valid && rsp.divide_by_zero, rsp.result == 32'd0, "divide by zero with nonzero result")
  `MALU_ASSERT_NEXT(a_md_start_busy, clk, rst, md_cmd.start, state == ST_MULDIV && !rsp.valid, "multiply/divide start did not enter busy state")

endmodule

/* sim/mips_alu_with_hi_lo_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for mips_alu_with_hi_lo_unit: directed corners, then random traffic.
// Depends on malu_pkg, malu_req_if, malu_rsp_if and the ALU top level.

module mips_alu_with_hi_lo_unit_test;

  // Codes 23..31 are unassigned; the block must answer them with zero.
  localparam logic [malu_pkg::OpW-1:0] OpUnusedLo = 5'd23;
  localparam logic [malu_pkg::OpW-1:0] OpUnusedHi = 5'd31;

  // Watchdog limit for a run of under 1400 beats; take a wide margin.
  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;   // long response back-pressure stretch
  localparam int DrainCycles = 40;   // idle tail before the final check

  typedef struct packed {
    logic [malu_pkg::OpW-1:0]   op;
    logic [malu_pkg::DataW-1:0] a;
    logic [malu_pkg::DataW-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic [malu_pkg::OpW-1:0]   op;
    logic [malu_pkg::DataW-1:0] result;
    logic                       dz;
  } alu_out_t;

  logic clk;
  logic rst;

  malu_req_if req_ch ();
  malu_rsp_if rsp_ch ();

  mips_alu_with_hi_lo_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Stimulus and scoreboard state.
  alu_op_t  op_queue[$];      // beats waiting to be offered
  alu_out_t alu_out_q[$];     // predicted responses, oldest first
  logic [malu_pkg::DataW-1:0] hi_q;     // predicted HI
  logic [malu_pkg::DataW-1:0] lo_q;     // predicted LO
  logic req_taken;            // request beat accepted at last rising edge
  logic rsp_hold;             // forces rsp.ready low during the long stall
  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatches;
  int   cycle_count;
  event hold_kick;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: result of one ALU beat, updating the HI/LO copy as the block does.
  // ---------------------------------------------------------------------------
  function automatic alu_out_t compute_alu(input alu_op_t r);
    alu_out_t o;
    logic [4:0] sh;
    logic [63:0] prod;
    logic [malu_pkg::DataW-1:0] ma, mb, q, rm;
    o.op = r.op;
    o.result = '0;
    o.dz = 1'b0;
    sh = r.b[4:0];
    case (r.op)
      malu_pkg::OP_ADDIU: o.result = r.a + {{16{r.b[15]}}, r.b[15:0]};
      malu_pkg::OP_ADDU:  o.result = r.a + r.b;
      malu_pkg::OP_SUBU:  o.result = r.a - r.b;
      malu_pkg::OP_AND:   o.result = r.a & r.b;
      malu_pkg::OP_ANDI:  o.result = r.a & {16'h0000, r.b[15:0]};
      malu_pkg::OP_OR:    o.result = r.a | r.b;
      malu_pkg::OP_ORI:   o.result = r.a | {16'h0000, r.b[15:0]};
      malu_pkg::OP_XOR:   o.result = r.a ^ r.b;
      malu_pkg::OP_XORI:  o.result = r.a ^ {16'h0000, r.b[15:0]};
      malu_pkg::OP_SLL, malu_pkg::OP_SLLV: o.result = r.a << sh;
      malu_pkg::OP_SRA, malu_pkg::OP_SRAV: o.result = $signed(r.a) >>> sh;
      malu_pkg::OP_SRL, malu_pkg::OP_SRLV: o.result = r.a >> sh;
      malu_pkg::OP_MULT: begin
        prod = $signed({{32{r.a[31]}}, r.a}) * $signed({{32{r.b[31]}}, r.b});
        {hi_q, lo_q} = prod;
      end
      malu_pkg::OP_MULTU: begin
        prod = {32'h0, r.a} * {32'h0, r.b};
        {hi_q, lo_q} = prod;
      end
      malu_pkg::OP_DIV: begin
        if (r.b == '0) begin
          o.dz = 1'b1;
        end else begin
          // Work on magnitudes: quotient truncates toward zero, remainder
          // follows the dividend; most-negative / -1 wraps naturally.
          ma = r.a[31] ? (32'd0 - r.a) : r.a;
          mb = r.b[31] ? (32'd0 - r.b) : r.b;
          q  = ma / mb;
          rm = ma % mb;
          hi_q = r.a[31] ? (32'd0 - rm) : rm;
          lo_q = (r.a[31] ^ r.b[31]) ? (32'd0 - q) : q;
        end
      end
      malu_pkg::OP_DIVU: begin
        if (r.b == '0) begin
          o.dz = 1'b1;
        end else begin
          hi_q = r.a % r.b;
          lo_q = r.a / r.b;
        end
      end
      malu_pkg::OP_MTHI: hi_q = r.a;
      malu_pkg::OP_MTLO: lo_q = r.a;
      malu_pkg::OP_MFHI: o.result = hi_q;
      malu_pkg::OP_MFLO: o.result = lo_q;
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: driver at the falling edge, acceptance seen at the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_req
    alu_op_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = op_queue.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.op        <= nxt.op;
        req_ch.operand_a <= nxt.a;
        req_ch.operand_b <= nxt.b;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Accepted request beat -> prediction goes on the back of the queue.
  always @(posedge clk) begin : watch_req
    alu_op_t beat;
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      beat.op = req_ch.op;
      beat.a  = req_ch.operand_a;
      beat.b  = req_ch.operand_b;
      alu_out_q.push_back(compute_alu(beat));
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random ready, plus the long hold-off when kicked.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold-off runs in its own process, counted on rising edges.
  always begin
    @(hold_kick);
    rsp_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rsp_hold = 1'b0;
  end

  // Each response beat is checked against the oldest prediction.
  always @(posedge clk) begin : check_rsp
    alu_out_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (alu_out_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: response beat with nothing outstanding: result %h dz %b",
                   $realtime, rsp_ch.result, rsp_ch.divide_by_zero);
        mismatches++;
      end else begin
        want = alu_out_q.pop_front();
        if (rsp_ch.result !== want.result || rsp_ch.divide_by_zero !== want.dz) begin
          if (mismatches < 10)
            $display("%0t: op %0d: result %h dz %b, expected result %h dz %b",
                     $realtime, want.op, rsp_ch.result, rsp_ch.divide_by_zero,
                     want.result, want.dz);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_op(input logic [malu_pkg::OpW-1:0] op,
                         input logic [malu_pkg::DataW-1:0] a,
                         input logic [malu_pkg::DataW-1:0] b);
    alu_op_t r;
    r.op = op;
    r.a  = a;
    r.b  = b;
    op_queue.push_back(r);
  endtask

  // Operands lean on the corners; plain random the rest of the time.
  function automatic logic [malu_pkg::DataW-1:0] pick_operand();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(40);
      5: return 32'd0 - $urandom_range(1, 40);
      6: return {16'($urandom_range(16'hFFFF)), 16'(16'h8000 | $urandom_range(16'h7FFF))};
      default: return $urandom;
    endcase
  endfunction

  // Sequences: mul/div then HI and LO read back, MTHI/MTLO then one read, or single ops.
  task automatic gen_traffic(input int n);
    int made;
    logic [malu_pkg::OpW-1:0] op;
    logic [malu_pkg::DataW-1:0] b;
    made = 0;
    while (made < n) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: begin
          op = malu_pkg::OpW'($urandom_range(malu_pkg::OP_MULT, malu_pkg::OP_DIVU));
          b  = ($urandom_range(7) == 0) ? '0 : pick_operand();
          push_op(op, pick_operand(), b);
          push_op(malu_pkg::OP_MFHI, $urandom, $urandom);
          push_op(malu_pkg::OP_MFLO, $urandom, $urandom);
          made += 3;
        end
        6, 7: begin
          push_op(malu_pkg::OpW'($urandom_range(malu_pkg::OP_MTHI, malu_pkg::OP_MTLO)),
                  pick_operand(), $urandom);
          push_op(malu_pkg::OpW'($urandom_range(malu_pkg::OP_MFHI, malu_pkg::OP_MFLO)),
                  $urandom, $urandom);
          made += 2;
        end
        8: begin
          push_op(malu_pkg::OpW'($urandom_range(OpUnusedLo, OpUnusedHi)), $urandom, $urandom);
          made++;
        end
        default: begin
          push_op(malu_pkg::OpW'($urandom_range(malu_pkg::OP_ADDIU, malu_pkg::OP_MFLO)),
                  pick_operand(), pick_operand());
          made++;
        end
      endcase
    end
  endtask

  // Waits until every queued beat has gone in and every response has come out.
  task automatic drain();
    while (op_queue.size() != 0 || req_ch.valid || alu_out_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    rsp_hold = 1'b0;
    req_taken = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    hi_q = '0;
    lo_q = '0;
    req_ch.valid = 1'b0;
    req_ch.op = malu_pkg::OP_ADDU;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    rsp_ch.ready = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners. HI read first to see the reset value.
    push_op(malu_pkg::OP_MFHI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_ADDIU, 32'h7FFF_FFFF, 32'hFFFF_8000);   // negative immediate
    push_op(malu_pkg::OP_ADDU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_SUBU, 32'h0000_0000, 32'h0000_0001);
    push_op(malu_pkg::OP_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    push_op(malu_pkg::OP_ANDI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // upper bits ignored
    push_op(malu_pkg::OP_OR, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_ORI, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_XOR, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
    push_op(malu_pkg::OP_XORI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_SLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // amount 31
    push_op(malu_pkg::OP_SRA, 32'h8000_0000, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_SRL, 32'h8000_0000, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_SLLV, 32'h8000_0001, 32'hFFFF_FFE1);    // amount 1
    push_op(malu_pkg::OP_SRAV, 32'h7FFF_FFFF, 32'hFFFF_FFE0);    // amount 0
    push_op(malu_pkg::OP_SRLV, 32'hFFFF_FFFF, 32'h0000_0010);
    push_op(malu_pkg::OP_MULT, 32'h8000_0000, 32'h8000_0000);
    push_op(malu_pkg::OP_MFHI, 32'h0, 32'h0);
    push_op(malu_pkg::OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(malu_pkg::OP_MFLO, 32'h0, 32'h0);
    push_op(malu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);     // signed overflow wraps
    push_op(malu_pkg::OP_MFHI, 32'h0, 32'h0);
    push_op(malu_pkg::OP_DIV, 32'hFFFF_FFF9, 32'h0000_0002);     // -7 / 2: truncation
    push_op(malu_pkg::OP_MFLO, 32'h0, 32'h0);
    push_op(malu_pkg::OP_DIV, 32'h1234_5678, 32'h0000_0000);     // zero divisor, HI/LO kept
    push_op(malu_pkg::OP_DIVU, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(malu_pkg::OP_MFHI, 32'h0, 32'h0);
    push_op(malu_pkg::OP_DIVU, 32'hFFFF_FFFF, 32'h0000_0003);
    push_op(malu_pkg::OP_MTHI, 32'hDEAD_BEEF, 32'h0);
    push_op(malu_pkg::OP_MTLO, 32'hFFFF_FFFF, 32'h0);
    push_op(malu_pkg::OP_MFLO, 32'h0, 32'h0);
    push_op(OpUnusedHi, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // No idling, opened by a long response stall while requests keep coming.
    set_idling(0, 0);
    -> hold_kick;
    gen_traffic(330);
    drain();

    set_idling(50, 0);
    gen_traffic(330);
    drain();

    set_idling(0, 50);
    gen_traffic(330);
    drain();

    set_idling(8, 8);
    gen_traffic(330);
    drain();

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && alu_out_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
